FILE: hw/rtl/tce_pkg.sv
`default_nettype none
package tce_pkg;

	localparam int unsigned RATE_W    = 19;
	localparam int unsigned TEMPO_W   = 26;
	localparam int unsigned POS_W     = 44;
	localparam int unsigned SAMPLES_W = 16;
	localparam int unsigned TIME_W    = 64;
	localparam int unsigned FLAGS_W   = 6;

	// samples * tempo * 2^4
	localparam int unsigned NUM_W = SAMPLES_W + TEMPO_W + 4;
	// 60 * rate fits in 25 bits
	localparam int unsigned DEN_W = RATE_W + 6;
	// pos + quotient before saturation
	localparam int unsigned SUM_W = NUM_W + 2;

	localparam int unsigned S_DATA_W = 152;
	localparam int unsigned S_USER_W = 2;
	localparam int unsigned M_DATA_W = 144;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
	localparam int JUMP_LSB = 1049;

	localparam int unsigned FLAG_PLAYING = 0;
	localparam int unsigned FLAG_TEMPO   = 3;
	localparam int unsigned FLAG_POS     = 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIX
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tce_mul.sv
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
module tce_mul #(
	parameter int unsigned A_W = tce_pkg::SAMPLES_W,
	parameter int unsigned B_W = tce_pkg::TEMPO_W
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire  [A_W-1:0]          a,
	input  wire  [B_W-1:0]          b,
	output tce_pkg::unit_stat_t     stat,
	output logic [A_W+B_W-1:0]      prod
);

	localparam int unsigned P_W   = A_W + B_W;
	localparam int unsigned CNT_W = $clog2(A_W);

	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [P_W-1:0]   acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(A_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[P_W-2:0], 1'b0} + (a_q[A_W-1] ? P_W'(b_q) : '0);
			a_q   <= {a_q[A_W-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;

endmodule
`default_nettype wire

FILE: hw/rtl/tce_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module tce_div #(
	parameter int unsigned N_W = tce_pkg::NUM_W,
	parameter int unsigned D_W = tce_pkg::DEN_W
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire  [N_W-1:0]          num,
	input  wire  [D_W-1:0]          den,
	output tce_pkg::unit_stat_t     stat,
	output logic [N_W-1:0]          quot,
	output logic [D_W-1:0]          rem
);

	localparam int unsigned CNT_W = $clog2(N_W);

	logic [N_W-1:0]   num_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             ge;

	assign trial = {rem_q, num_q[N_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(N_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in at the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[N_W-2:0], ge};
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = num_q;
	assign rem       = rem_q;

endmodule
`default_nettype wire

FILE: hw/rtl/transport_change_emitter.sv
`default_nettype none
// Transport change emitter.
// One slave transaction per audio block carries play state, tempo, position,
// block length and start timestamp; tempo_valid and pos_valid ride in tuser.
// At most one master transaction (the event) comes out per block, in the cycle
// after the block is taken, from an output register.
// The cfg channel writes the sample rate (always ready); write it only while
// the block is idle.
// A block that is playing with valid tempo and position (and a nonzero rate)
// projects its end position through a serial multiplier (16 steps) and a
// restoring divider (46 steps): s_tready stays low through the MUL, DIV and
// FIX states after such a block. After any other block s_tready stays high
// unless an event is stalled.
// A stalled event holds m_tdata; s_tready stays low until the waiting event
// is taken or is taken in the same cycle.
// Reset clears the history, so the first block after reset always emits, and
// sets the sample rate to 48000.
module transport_change_emitter (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// playing[0], tempo_bpm[26:1], position[70:27], block_samples[86:71],
	// block_time[150:87], zero pad[151]
	input  wire  [tce_pkg::S_DATA_W-1:0]     s_tdata,
	// tempo_valid[0], pos_valid[1]
	input  wire  [tce_pkg::S_USER_W-1:0]     s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// event_flags[5:0], event_tempo[31:6], event_position[75:32],
	// event_time[139:76], zero pad[143:140]
	output logic [tce_pkg::M_DATA_W-1:0]     m_tdata,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [tce_pkg::RATE_W-1:0]       cfg_data
);

	localparam int unsigned POS_W   = tce_pkg::POS_W;
	localparam int unsigned NUM_W   = tce_pkg::NUM_W;
	localparam int unsigned DEN_W   = tce_pkg::DEN_W;
	localparam int unsigned SUM_W   = tce_pkg::SUM_W;
	localparam int unsigned PROD_W  = tce_pkg::SAMPLES_W + tce_pkg::TEMPO_W;
	localparam int unsigned SAT_W   = SUM_W - POS_W + 1;

	// input unpacking
	logic                              in_playing;
	logic                              in_tempo_valid;
	logic                              in_pos_valid;
	logic [tce_pkg::TEMPO_W-1:0]       in_tempo;
	logic signed [POS_W-1:0]           in_pos;
	logic [tce_pkg::SAMPLES_W-1:0]     in_samples;
	logic [tce_pkg::TIME_W-1:0]        in_time;

	assign in_playing     = s_tdata[0];
	assign in_tempo       = s_tdata[26:1];
	assign in_pos         = s_tdata[70:27];
	assign in_samples     = s_tdata[86:71];
	assign in_time        = s_tdata[150:87];
	assign in_tempo_valid = s_tuser[0];
	assign in_pos_valid   = s_tuser[1];

	tce_pkg::state_t                   state_q, state_d;
	logic [tce_pkg::RATE_W-1:0]        rate_q;
	logic                              prev_playing_q;
	logic [tce_pkg::TEMPO_W-1:0]       prev_tempo_q;
	logic signed [POS_W-1:0]           expected_q;
	logic [31:0]                       samples_q;
	logic                              emitted_q;
	logic signed [POS_W-1:0]           pos_q;
	logic signed [SUM_W-1:0]           sum_q;
	logic                              rnz_q;
	logic                              m_tvalid_q;
	logic [tce_pkg::M_DATA_W-1:0]      m_tdata_q;

	logic                              accept;
	logic                              need_proj;
	logic signed [POS_W:0]             diff;
	logic                              jump;
	logic [32:0]                       samples_sum;
	logic [31:0]                       samples_sat;
	logic                              refresh;
	logic                              emit;
	logic [tce_pkg::FLAGS_W-1:0]       flags;
	logic [DEN_W-1:0]                  den;
	logic                              mul_start;
	logic                              div_start;
	logic [PROD_W-1:0]                 prod;
	logic [NUM_W-1:0]                  quot;
	logic [DEN_W-1:0]                  rem;
	tce_pkg::unit_stat_t               mul_stat;
	tce_pkg::unit_stat_t               div_stat;
	logic signed [SUM_W-1:0]           fixed;
	logic signed [POS_W-1:0]           fixed_sat;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == tce_pkg::ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign need_proj = in_playing && in_tempo_valid && in_pos_valid && (rate_q != '0);

	// event decision
	assign diff = {in_pos[POS_W-1], in_pos} - {expected_q[POS_W-1], expected_q};
	assign jump = in_playing && prev_playing_q && in_pos_valid &&
		(diff >= tce_pkg::JUMP_LSB || diff <= -tce_pkg::JUMP_LSB);
	assign samples_sum = {1'b0, samples_q} + 33'(in_samples);
	assign samples_sat = samples_sum[32] ? '1 : samples_sum[31:0];
	assign refresh     = in_playing && (samples_sat >= 32'(rate_q));
	assign emit = (in_playing != prev_playing_q) ||
		(in_tempo_valid && (in_tempo != prev_tempo_q)) ||
		jump || refresh || !emitted_q;

	always_comb begin
		flags = '0;
		flags[tce_pkg::FLAG_PLAYING] = in_playing;
		flags[tce_pkg::FLAG_TEMPO]   = in_tempo_valid;
		flags[tce_pkg::FLAG_POS]     = in_pos_valid;
	end

	// 60 * rate = 64 * rate - 4 * rate
	assign den = DEN_W'({rate_q, 6'b0}) - DEN_W'({rate_q, 2'b0});

	assign mul_start = accept && need_proj;
	assign div_start = (state_q == tce_pkg::ST_MUL) && mul_stat.done;

	tce_mul #(
		.A_W(tce_pkg::SAMPLES_W),
		.B_W(tce_pkg::TEMPO_W)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (in_samples),
		.b     (in_tempo),
		.stat  (mul_stat),
		.prod  (prod)
	);

	tce_div #(
		.N_W(NUM_W),
		.D_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ({prod, 4'b0}),
		.den   (den),
		.stat  (div_stat),
		.quot  (quot),
		.rem   (rem)
	);

	// round toward zero, then clamp to the 44-bit range
	assign fixed = sum_q + SUM_W'(rnz_q && sum_q[SUM_W-1]);
	always_comb begin
		if (fixed[SUM_W-1:POS_W-1] == '0 || fixed[SUM_W-1:POS_W-1] == {SAT_W{1'b1}}) begin
			fixed_sat = fixed[POS_W-1:0];
		end else if (fixed[SUM_W-1]) begin
			fixed_sat = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			fixed_sat = {1'b0, {(POS_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tce_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tce_pkg::ST_IDLE: begin
				if (mul_start) state_d = tce_pkg::ST_MUL;
			end
			tce_pkg::ST_MUL: begin
				if (mul_stat.done) state_d = tce_pkg::ST_DIV;
			end
			tce_pkg::ST_DIV: begin
				if (div_stat.done) state_d = tce_pkg::ST_FIX;
			end
			tce_pkg::ST_FIX: begin
				state_d = tce_pkg::ST_IDLE;
			end
			default: state_d = tce_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q         <= tce_pkg::RATE_RESET;
			prev_playing_q <= 1'b0;
			prev_tempo_q   <= '0;
			expected_q     <= '0;
			samples_q      <= '0;
			emitted_q      <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) rate_q <= cfg_data;
			if (accept) begin
				prev_playing_q <= in_playing;
				prev_tempo_q   <= in_tempo;
				emitted_q      <= emitted_q || emit;
				samples_q      <= emit ? '0 : samples_sat;
				if (!need_proj) expected_q <= in_pos;
				m_tvalid_q     <= emit;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (state_q == tce_pkg::ST_FIX) expected_q <= fixed_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= in_pos;
			if (emit) begin
				m_tdata_q <= {4'b0, in_time, in_pos, in_tempo, flags};
			end
		end
		if (state_q == tce_pkg::ST_DIV && div_stat.done) begin
			sum_q <= SUM_W'(pos_q) + SUM_W'(quot);
			rnz_q <= rem != '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == tce_pkg::ST_IDLE)
		else $error("s_tready high outside idle");
	a_mul_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_stat.busy)
		else $error("divider did not start after multiply");
	a_first_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !emitted_q) |=> m_tvalid)
		else $error("first block after reset did not emit");
	a_emitted_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		emitted_q |=> emitted_q)
		else $error("emitted flag cleared");
`endif

endmodule
`default_nettype wire
